[src/kgr_pkg.sv]
package kgr_pkg;

	localparam int DATA_W = 32;
	localparam int GS_W = 5;
	localparam int RESULT_CAP = 16;
	localparam int MAX_GROUP_DEF = 16;
	localparam int IDX_W = 4;

	typedef struct packed {
		logic signed [DATA_W-1:0] item_value;
		logic list_end;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic run_last;
		logic out_list_end;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic bank;
		logic [IDX_W-1:0] idx;
		logic [DATA_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic bank;
		logic [GS_W-1:0] count;
		logic rev;
		logic ends;
	} job_t;

endpackage

[src/kgr_front.sv]
module kgr_front #(
	parameter int MAX_GROUP = kgr_pkg::MAX_GROUP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  kgr_pkg::in_item_t item,
	input  logic cfg_we,
	input  logic [kgr_pkg::GS_W-1:0] cfg_data,
	output kgr_pkg::wr_req_t wr_req,
	output logic job_push,
	output kgr_pkg::job_t job,
	input  logic job_full
);

	localparam int DEPTH = (MAX_GROUP < kgr_pkg::RESULT_CAP) ? MAX_GROUP : kgr_pkg::RESULT_CAP;
	localparam logic [kgr_pkg::GS_W-1:0] KMAX = kgr_pkg::GS_W'(DEPTH);

	logic [kgr_pkg::GS_W-1:0] gs_q;
	logic [kgr_pkg::GS_W-1:0] fill_q;
	logic bank_q;
	logic [kgr_pkg::GS_W-1:0] k_eff;
	logic [kgr_pkg::GS_W-1:0] n;
	logic accept;
	logic emit;

	always_comb begin
		if (gs_q == '0) begin
			k_eff = kgr_pkg::GS_W'(1);
		end else if (gs_q > KMAX) begin
			k_eff = KMAX;
		end else begin
			k_eff = gs_q;
		end
	end

	assign full = job_full;
	assign accept = push && !job_full;
	assign n = fill_q + kgr_pkg::GS_W'(1);
	assign emit = (n >= k_eff) || item.list_end;

	assign wr_req.en = accept;
	assign wr_req.bank = bank_q;
	assign wr_req.idx = fill_q[kgr_pkg::IDX_W-1:0];
	assign wr_req.data = item.item_value;

	assign job_push = accept && emit;
	assign job.bank = bank_q;
	assign job.count = n;
	assign job.rev = (n >= k_eff);
	assign job.ends = item.list_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= kgr_pkg::GS_W'(1);
			fill_q <= '0;
			bank_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gs_q <= cfg_data;
			end
			if (accept) begin
				if (emit) begin
					fill_q <= '0;
					bank_q <= !bank_q;
				end else begin
					fill_q <= n;
				end
			end
		end
	end

endmodule

[src/kgr_job_fifo.sv]
module kgr_job_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  kgr_pkg::job_t wdata,
	output logic full,
	input  logic pop,
	output kgr_pkg::job_t rdata,
	output logic empty
);

	kgr_pkg::job_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[src/kgr_back.sv]
module kgr_back #(
	parameter int MAX_GROUP = kgr_pkg::MAX_GROUP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  kgr_pkg::wr_req_t wr_req,
	input  kgr_pkg::job_t job,
	input  logic job_empty,
	output logic job_pop,
	output logic empty,
	input  logic pop,
	output kgr_pkg::out_item_t result
);

	localparam int DEPTH = (MAX_GROUP < kgr_pkg::RESULT_CAP) ? MAX_GROUP : kgr_pkg::RESULT_CAP;
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MEM_DEPTH = 2 * (2 ** IW);

	logic [kgr_pkg::DATA_W-1:0] mem [MEM_DEPTH];

	logic [kgr_pkg::GS_W-1:0] idx_q;
	logic [kgr_pkg::GS_W-1:0] last_idx;
	logic [kgr_pkg::GS_W-1:0] rd_idx;
	logic issue;
	logic is_last;

	logic [kgr_pkg::DATA_W-1:0] rdata_s1;
	logic valid_s1;
	logic last_s1;
	logic ends_s1;

	kgr_pkg::out_item_t oq_q [4];
	logic [1:0] oq_wr_q;
	logic [1:0] oq_rd_q;
	logic [2:0] oq_cnt_q;
	logic oq_pop;

	assign last_idx = job.count - kgr_pkg::GS_W'(1);
	assign rd_idx = job.rev ? (last_idx - idx_q) : idx_q;
	assign is_last = (idx_q == last_idx);
	assign issue = !job_empty && ((oq_cnt_q + {2'b00, valid_s1}) <= 3'd2);
	assign job_pop = issue && is_last;

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[{wr_req.bank, wr_req.idx[IW-1:0]}] <= wr_req.data;
		end
		if (issue) begin
			rdata_s1 <= mem[{job.bank, rd_idx[IW-1:0]}];
			last_s1 <= is_last;
			ends_s1 <= job.ends;
		end
		if (valid_s1) begin
			oq_q[oq_wr_q] <= '{out_value: rdata_s1, run_last: last_s1,
				out_list_end: last_s1 && ends_s1};
		end
	end

	assign empty = (oq_cnt_q == 3'd0);
	assign result = oq_q[oq_rd_q];
	assign oq_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_s1 <= 1'b0;
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				idx_q <= is_last ? '0 : idx_q + kgr_pkg::GS_W'(1);
			end
			if (valid_s1) begin
				oq_wr_q <= oq_wr_q + 2'd1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 2'd1;
			end
			if (valid_s1 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 3'd1;
			end else if (oq_pop && !valid_s1) begin
				oq_cnt_q <= oq_cnt_q - 3'd1;
			end
		end
	end

endmodule

[src/k_group_reverser.sv]
// A group's first result follows its job through the job queue, read stage and output queue.
// Results of a group leave one per cycle while popped, from a two-bank store read by the back end.
// Throughput: one request per cycle is sustained while results are popped each cycle.
// Requests stall only while both store banks hold groups still waiting to be read out.
// Reset clears the fill count, the queues and sets the group size to 1; store contents stay undefined.
module k_group_reverser #(
	parameter int MAX_GROUP = kgr_pkg::MAX_GROUP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  kgr_pkg::in_item_t item,
	output logic empty,
	input  logic pop,
	output kgr_pkg::out_item_t result,
	input  logic cfg_we,
	input  logic [kgr_pkg::GS_W-1:0] cfg_data
);

	kgr_pkg::wr_req_t wr_req;
	kgr_pkg::job_t job_in;
	kgr_pkg::job_t job_out;
	logic job_push;
	logic job_pop;
	logic job_full;
	logic job_empty;

	kgr_front #(.MAX_GROUP(MAX_GROUP)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.wr_req(wr_req),
		.job_push(job_push),
		.job(job_in),
		.job_full(job_full)
	);

	kgr_job_fifo u_jobs (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.wdata(job_in),
		.full(job_full),
		.pop(job_pop),
		.rdata(job_out),
		.empty(job_empty)
	);

	kgr_back #(.MAX_GROUP(MAX_GROUP)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_req(wr_req),
		.job(job_out),
		.job_empty(job_empty),
		.job_pop(job_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

[src/kgr_checker.sv]
module kgr_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input kgr_pkg::out_item_t result
);

	assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("queues not clear after reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.out_list_end) |-> result.run_last)
		else $error("list end on a result that does not close its run");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule

bind k_group_reverser kgr_checker u_kgr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.empty(empty),
	.pop(pop),
	.result(result)
);
